[hdl/sec_pkg.sv]
`default_nettype none
package sec_pkg;

    localparam int POS_W      = 20;
    localparam int STEP_W     = 15;
    localparam int THR_W      = 16;
    localparam int WGT_W      = 20;
    localparam int COST_W     = 48;
    localparam int SPEED_W    = 32;
    localparam int TOTAL_W    = COST_W + 2;
    localparam int MUL_W      = 64;
    localparam int DVD_W      = 48;
    localparam int DVS_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int OP_W       = 2;

    localparam int S_TDATA_W  = 6 * POS_W;
    localparam int S_TUSER_W  = OP_W;
    localparam int M_TDATA_W  = COST_W;
    localparam int M_TUSER_W  = 2;

    localparam int MAX_RANGES_DEF = 8;

    localparam logic [OP_W-1:0] OP_EVAL = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLR  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_CLEAR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXCEED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_SPEED  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BASE       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_EN  = 3'd7;

    localparam logic [STEP_W-1:0] RST_TIME_STEP  = 15'd4096;
    localparam logic [THR_W-1:0]  RST_STOP_THR   = 16'd819;
    localparam logic [WGT_W-1:0]  RST_KEEP_CLEAR = 20'd2560;
    localparam logic [WGT_W-1:0]  RST_EXCEED     = 20'd256000;
    localparam logic [WGT_W-1:0]  RST_LOW_SPEED  = 20'd2560;
    localparam logic [WGT_W-1:0]  RST_CRUISE     = 20'd2560;
    localparam logic [WGT_W-1:0]  RST_BASE       = 20'd256000;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [1:0] {
        T_KEEP   = 2'd0,
        T_LIMIT  = 2'd1,
        T_CRUISE = 2'd2,
        T_END    = 2'd3
    } term_t;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SPEED = 10'b0000000010,
        S_SCAN  = 10'b0000000100,
        S_NEXT  = 10'b0000001000,
        S_WB    = 10'b0000010000,
        S_WT    = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_M1    = 10'b0010000000,
        S_M2    = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    function automatic logic [COST_W-1:0] clamp_cost(input logic [MUL_W-1:0] v);
        logic [COST_W-1:0] r;
        if (|v[MUL_W-1:COST_W]) r = COST_MAX;
        else r = v[COST_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/sec_ram.sv]
`default_nettype none
module sec_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

[hdl/sec_mul.sv]
`default_nettype none
module sec_mul (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [sec_pkg::MUL_W-1:0] a,
    input  wire logic [sec_pkg::MUL_W-1:0] b,
    output logic      [sec_pkg::MUL_W-1:0] p,
    output sec_pkg::unit_stat_t            stat
);
    import sec_pkg::*;

    localparam int CNT_W = $clog2(MUL_W);

    logic [MUL_W-1:0] a_reg, b_reg, acc_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [MUL_W+1:0] sum_next;

    // One multiplier bit per cycle, most significant first. The partial
    // product only grows, so an overflow seen on the way saturates the result.
    always_comb
    begin
        sum_next = {1'b0, acc_reg, 1'b0}
                 + {2'b00, (b_reg[MUL_W-1] ? a_reg : {MUL_W{1'b0}})};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(MUL_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            acc_reg <= sum_next[MUL_W-1:0];
            ovf_reg <= ovf_reg | (|sum_next[MUL_W+1:MUL_W]);
            b_reg   <= {b_reg[MUL_W-2:0], 1'b0};
        end
    end

    assign p         = ovf_reg ? {MUL_W{1'b1}} : acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule
`default_nettype wire

[hdl/sec_div.sv]
`default_nettype none
module sec_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [sec_pkg::DVD_W-1:0] dividend,
    input  wire logic [sec_pkg::DVS_W-1:0] divisor,
    output logic      [sec_pkg::DVD_W-1:0] quotient,
    output sec_pkg::unit_stat_t            stat
);
    import sec_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0] q_reg;
    logic [DVS_W-1:0] rem_reg, dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DVS_W:0]   trial;
    logic             ge;
    logic [DVS_W:0]   diff;

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of the top of q_reg while quotient bits enter at the bottom.
    always_comb
    begin
        trial = {rem_reg, q_reg[DVD_W-1]};
        ge    = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(DVD_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            q_reg   <= {q_reg[DVD_W-2:0], ge};
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule
`default_nettype wire

[hdl/speed_edge_cost_core.sv]
`default_nettype none
// Speed cost of one position-time grid edge, built around a bit-serial
// 64-bit saturating multiplier and a bit-serial 48/20-bit divider, one at a
// time. Add, clear and unused requests, and a backward edge (which answers with
// the infinite flag), put their result through the result registers into the
// output register. An evaluate request runs the speed division, the
// keep-clear scan of the range store (only when the speed is below the stop
// threshold), a decision per term whether it applies followed by a finishing
// step, and for each active term two multiplications for the weight
// scaling; the limit term adds a division and one multiplication (two when
// over the limit), the cruise term one more multiplication. The result then
// moves to the output register; the serial multiplier sets most of the
// evaluation time. A new request is taken only after the previous result has
// reached the output register. The range store is a small RAM holding up to
// MAX_RANGES entries; entries are never sorted or merged.
module speed_edge_cost_core #(
    parameter int MAX_RANGES = sec_pkg::MAX_RANGES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // tdata: start_position, end_position, limit, cruise target,
    //        range_low, range_high (20 bits each, lowest first)
    input  wire logic [sec_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: operation
    input  wire logic [sec_pkg::S_TUSER_W-1:0]  s_tuser,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // tdata: edge_cost
    output logic      [sec_pkg::M_TDATA_W-1:0]  m_tdata,
    // tuser: cost_infinite, status
    output logic      [sec_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           cfg_we,
    input  wire logic [sec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sec_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sec_pkg::*;

    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int AW    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int ENT_W = 2 * POS_W;

    // configuration
    logic [STEP_W-1:0] ts_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [WGT_W-1:0]  kc_reg, ex_reg, lo_reg, cr_reg, base_reg;
    logic              en_reg;

    state_t state_reg, state_next;
    term_t  term_reg, term_next;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               scan_vld_reg, scan_vld_next;
    logic               hit_reg, hit_next;
    logic [POS_W-1:0]   end_reg, end_next;
    logic [POS_W-1:0]   lim_reg, lim_next;
    logic [POS_W-1:0]   cru_reg, cru_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic [MUL_W-1:0]   kt_reg, kt_next;
    logic [DVD_W-1:0]   d_reg, d_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [COST_W-1:0]  res_cost_reg, res_cost_next;
    logic               res_inf_reg, res_inf_next;
    logic               res_stat_reg, res_stat_next;
    logic [COST_W-1:0]  out_cost_reg, out_cost_next;
    logic               out_inf_reg, out_inf_next;
    logic               out_stat_reg, out_stat_next;
    logic               out_vld_reg, out_vld_next;

    logic [POS_W-1:0] in_start, in_end, in_lim, in_cru, in_lo, in_hi;
    logic [OP_W-1:0]  in_op;

    logic [STEP_W-1:0]  eff_step;
    logic               over, issue, match;
    logic [SPEED_W-1:0] lim_diff, cru_diff;
    logic [WGT_W-1:0]   term_w;

    logic             mul_start, div_start, ram_we;
    logic [MUL_W-1:0] mul_a, mul_b, mul_p;
    logic [DVD_W-1:0] div_dvd, div_q;
    logic [DVS_W-1:0] div_dvs;
    logic [ENT_W-1:0] ram_rdata;
    unit_stat_t       mul_stat, div_stat;

    assign in_start = s_tdata[POS_W-1:0];
    assign in_end   = s_tdata[2*POS_W-1:POS_W];
    assign in_lim   = s_tdata[3*POS_W-1:2*POS_W];
    assign in_cru   = s_tdata[4*POS_W-1:3*POS_W];
    assign in_lo    = s_tdata[5*POS_W-1:4*POS_W];
    assign in_hi    = s_tdata[6*POS_W-1:5*POS_W];
    assign in_op    = s_tuser;

    assign eff_step = (ts_reg == '0) ? STEP_W'(1) : ts_reg;
    assign over     = speed_reg > SPEED_W'(lim_reg);
    assign lim_diff = over ? speed_reg - SPEED_W'(lim_reg) : SPEED_W'(lim_reg) - speed_reg;
    assign cru_diff = (speed_reg >= SPEED_W'(cru_reg)) ? speed_reg - SPEED_W'(cru_reg)
                                                       : SPEED_W'(cru_reg) - speed_reg;
    assign issue    = scan_idx_reg < count_reg;
    assign match    = (ram_rdata[POS_W-1:0] <= end_reg)
                   && (ram_rdata[ENT_W-1:POS_W] >= end_reg);

    always_comb
    begin
        case (term_reg)
            T_KEEP:   term_w = kc_reg;
            T_LIMIT:  term_w = over ? ex_reg : lo_reg;
            T_CRUISE: term_w = cr_reg;
            default:  term_w = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg   <= RST_TIME_STEP;
            thr_reg  <= RST_STOP_THR;
            kc_reg   <= RST_KEEP_CLEAR;
            ex_reg   <= RST_EXCEED;
            lo_reg   <= RST_LOW_SPEED;
            cr_reg   <= RST_CRUISE;
            base_reg <= RST_BASE;
            en_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIME_STEP:  ts_reg   <= cfg_data[STEP_W-1:0];
                REG_STOP_THR:   thr_reg  <= cfg_data[THR_W-1:0];
                REG_KEEP_CLEAR: kc_reg   <= cfg_data[WGT_W-1:0];
                REG_EXCEED:     ex_reg   <= cfg_data[WGT_W-1:0];
                REG_LOW_SPEED:  lo_reg   <= cfg_data[WGT_W-1:0];
                REG_CRUISE:     cr_reg   <= cfg_data[WGT_W-1:0];
                REG_BASE:       base_reg <= cfg_data[WGT_W-1:0];
                REG_CRUISE_EN:  en_reg   <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        term_next     = term_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        scan_vld_next = scan_vld_reg;
        hit_next      = hit_reg;
        end_next      = end_reg;
        lim_next      = lim_reg;
        cru_next      = cru_reg;
        speed_next    = speed_reg;
        kt_next       = kt_reg;
        d_next        = d_reg;
        total_next    = total_reg;
        res_cost_next = res_cost_reg;
        res_inf_next  = res_inf_reg;
        res_stat_next = res_stat_reg;
        out_cost_next = out_cost_reg;
        out_inf_next  = out_inf_reg;
        out_stat_next = out_stat_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        mul_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        div_start     = 1'b0;
        div_dvd       = '0;
        div_dvs       = '0;
        ram_we        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_cost_next = '0;
                    res_inf_next  = 1'b0;
                    res_stat_next = 1'b0;
                    state_next    = S_OUT;
                    case (in_op)
                        OP_ADD:
                        begin
                            if (count_reg >= CNT_W'(MAX_RANGES))
                            begin
                                res_stat_next = 1'b1;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_CLR:
                        begin
                            count_next = '0;
                        end
                        OP_EVAL:
                        begin
                            if (in_end < in_start)
                            begin
                                res_cost_next = COST_MAX;
                                res_inf_next  = 1'b1;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                div_dvd    = {{(DVD_W - POS_W - 12){1'b0}},
                                              in_end - in_start, 12'b0};
                                div_dvs    = DVS_W'(eff_step);
                                end_next   = in_end;
                                lim_next   = (in_lim == '0) ? POS_W'(1) : in_lim;
                                cru_next   = in_cru;
                                total_next = '0;
                                state_next = S_SPEED;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SPEED:
            begin
                if (div_stat.done)
                begin
                    speed_next    = div_q[SPEED_W-1:0];
                    hit_next      = 1'b0;
                    term_next     = T_KEEP;
                    scan_idx_next = '0;
                    scan_vld_next = 1'b0;
                    if (div_q[SPEED_W-1:0] < SPEED_W'(thr_reg))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_NEXT;
                    end
                end
            end
            S_SCAN:
            begin
                // The RAM read port is registered, so read data arrives in the cycle after its address.
                scan_vld_next = issue;
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                if (scan_vld_reg && match)
                begin
                    hit_next   = 1'b1;
                    state_next = S_NEXT;
                end
                else if (!issue)
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (term_reg == T_END)
                begin
                    res_cost_next = clamp_cost(MUL_W'(total_reg));
                    state_next    = S_OUT;
                end
                else if ((term_reg == T_KEEP && hit_reg)
                      || (term_reg == T_LIMIT && speed_reg != SPEED_W'(lim_reg))
                      || (term_reg == T_CRUISE && en_reg))
                begin
                    mul_start  = 1'b1;
                    mul_a      = MUL_W'(term_w);
                    mul_b      = MUL_W'(base_reg);
                    state_next = S_WB;
                end
                else
                begin
                    term_next = term_t'(term_reg + 1'b1);
                end
            end
            S_WB:
            begin
                if (mul_stat.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mul_p;
                    mul_b      = MUL_W'(eff_step);
                    state_next = S_WT;
                end
            end
            S_WT:
            begin
                if (mul_stat.done)
                begin
                    kt_next = mul_p >> 20;
                    case (term_reg)
                        T_KEEP:
                        begin
                            total_next = total_reg + TOTAL_W'(clamp_cost(mul_p >> 20));
                            term_next  = T_LIMIT;
                            state_next = S_NEXT;
                        end
                        T_LIMIT:
                        begin
                            div_start  = 1'b1;
                            div_dvd    = {lim_diff, 16'b0};
                            div_dvs    = lim_reg;
                            state_next = S_DIV;
                        end
                        default:
                        begin
                            mul_start  = 1'b1;
                            mul_a      = mul_p >> 20;
                            mul_b      = MUL_W'(cru_diff);
                            state_next = S_M1;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    d_next     = div_q;
                    mul_start  = 1'b1;
                    mul_a      = kt_reg;
                    mul_b      = MUL_W'(div_q);
                    state_next = S_M1;
                end
            end
            S_M1:
            begin
                if (mul_stat.done)
                begin
                    if (term_reg == T_LIMIT && over)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = mul_p >> 16;
                        mul_b      = MUL_W'(d_reg);
                        state_next = S_M2;
                    end
                    else if (term_reg == T_LIMIT)
                    begin
                        total_next = total_reg + TOTAL_W'(clamp_cost(mul_p >> 16));
                        term_next  = T_CRUISE;
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        total_next = total_reg + TOTAL_W'(clamp_cost(mul_p >> 12));
                        term_next  = T_END;
                        state_next = S_NEXT;
                    end
                end
            end
            S_M2:
            begin
                if (mul_stat.done)
                begin
                    total_next = total_reg + TOTAL_W'(clamp_cost(mul_p >> 16));
                    term_next  = T_CRUISE;
                    state_next = S_NEXT;
                end
            end
            S_OUT:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_cost_next = res_cost_reg;
                    out_inf_next  = res_inf_reg;
                    out_stat_next = res_stat_reg;
                    out_vld_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            term_reg     <= T_KEEP;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            scan_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            term_reg     <= term_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            scan_vld_reg <= scan_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_next;
        end_reg      <= end_next;
        lim_reg      <= lim_next;
        cru_reg      <= cru_next;
        speed_reg    <= speed_next;
        kt_reg       <= kt_next;
        d_reg        <= d_next;
        total_reg    <= total_next;
        res_cost_reg <= res_cost_next;
        res_inf_reg  <= res_inf_next;
        res_stat_reg <= res_stat_next;
        out_cost_reg <= out_cost_next;
        out_inf_reg  <= out_inf_next;
        out_stat_reg <= out_stat_next;
    end

    sec_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .p     (mul_p),
        .stat  (mul_stat)
    );

    sec_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .stat     (div_stat)
    );

    sec_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_RANGES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({in_hi, in_lo}),
        .raddr (scan_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_cost_reg;
    assign m_tuser  = {out_stat_reg, out_inf_reg};
endmodule
`default_nettype wire

[hdl/sec_chk.sv]
`default_nettype none
module sec_chk (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [sec_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [sec_pkg::M_TUSER_W-1:0] m_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic                          cfg_we
);
    import sec_pkg::*;

    // A pending result is not dropped.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // One request at a time: accepting closes the input until it is answered.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // A backward edge reports saturated cost.
    a_inf_cost: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == COST_MAX) && !m_tuser[1])
        else $error("infinite flag without saturated cost");

    // A dropped add carries no cost.
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> (m_tdata == '0))
        else $error("full status with nonzero cost");

    // The user must rewrite registers only while the block is idle and its output empty; the core does not enforce it.
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> s_tready && !m_tvalid)
        else $error("configuration written while a request is in flight");
endmodule

bind speed_edge_cost_core sec_chk u_sec_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we)
);
`default_nettype wire
